/* rtl/core/tcw_pkg.sv */
package tcw_pkg;

  localparam int ColW     = 7;
  localparam int RowW     = 5;
  localparam int CharW    = 8;
  localparam int ColorW   = 4;
  localparam int AttrW    = 8;
  localparam int CellW    = CharW + AttrW;
  localparam int ReqW     = 2;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;

  localparam logic [ReqW-1:0] ReqWrite     = 2'd0;
  localparam logic [ReqW-1:0] ReqSetCursor = 2'd1;
  localparam logic [ReqW-1:0] ReqRead      = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgColumns = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRows    = 1'b1;

  localparam logic [CharW-1:0] CharNewline   = 8'd10;
  localparam logic [CharW-1:0] CharBackspace = 8'd8;
  localparam logic [CharW-1:0] CharSpace     = 8'h20;

  localparam logic [ColW-1:0] ColsReset = 7'd80;
  localparam logic [RowW-1:0] RowsReset = 5'd25;

  // ansi red/blue order is swapped against vga
  function automatic logic [ColorW-1:0] ansi_to_vga(input logic [ColorW-1:0] c);
    return {c[3], c[0], c[1], c[2]};
  endfunction

endpackage

/* rtl/core/tcw_req_if.sv */
interface tcw_req_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [CharW-1:0]  char_code;
  logic [ColorW-1:0] fg_color;
  logic [ColorW-1:0] bg_color;
  logic [ColW-1:0]   target_col;
  logic [RowW-1:0]   target_row;

  modport source (
    output valid, req_type, char_code, fg_color, bg_color, target_col, target_row,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, fg_color, bg_color, target_col, target_row,
    output ready
  );
endinterface

/* rtl/core/tcw_rsp_if.sv */
interface tcw_rsp_if import tcw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ColW-1:0]  cursor_col;
  logic [RowW-1:0]  cursor_row;
  logic [CharW-1:0] cell_char;
  logic [AttrW-1:0] cell_attr;

  modport source (
    output valid, cursor_col, cursor_row, cell_char, cell_attr,
    input  ready
  );
  modport sink (
    input  valid, cursor_col, cursor_row, cell_char, cell_attr,
    output ready
  );
endinterface

/* rtl/core/tcw_ram.sv */
module tcw_ram #(
  parameter int Width = 16,
  parameter int Depth = 2000,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tcw_addr_unit.sv */
module tcw_addr_unit import tcw_pkg::*; #(
  parameter int CntW = 12,
  localparam int SumW = CntW + 1
) (
  input  logic [RowW-1:0] a_i,
  input  logic [ColW-1:0] b_i,
  input  logic [CntW-1:0] c_i,
  output logic [SumW-1:0] sum_o
);

  logic [RowW+ColW-1:0] prod;

  assign prod  = a_i * b_i;
  assign sum_o = SumW'(prod) + SumW'(c_i);

endmodule

/* rtl/core/text_console_writer.sv */
// text console writer: a character cell store with a cursor
// req_if carries one request per transaction: write character, set cursor
// or read cell; rsp_if returns one transaction per request with the cursor
// after the request and, for a read, the cell's character and attribute.
// cfg_we_i/cfg_idx_i/cfg_data_i write columns_in_use (0) and rows_in_use (1);
// write them only while the block is idle.
// a request is taken in StIdle; ordinary writes, backspace, newline without
// scroll and set cursor load their result in StCalc, or in StDone if the
// output register is full; a read ends in StDone (registered memory read).
// a scroll walks all rows*cols cells of the two-port cell memory, one cell
// per cycle, through the shared multiply-add address unit, ending in StDone.
// after reset the block sweeps zeros into all MAX_COLS*MAX_ROWS cells
// with req_if.ready low; config writes still land.
// rsp_if has an output register: a new request is taken while a result
// waits, and the block holds the next result until the receiver takes the
// pending one.
module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tcw_req_if.sink             req_if,
  tcw_rsp_if.source           rsp_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int CntW  = $clog2(Depth + 1);
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SumW  = CntW + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  localparam logic [2:0] StClear    = 3'd0;
  localparam logic [2:0] StIdle     = 3'd1;
  localparam logic [2:0] StCalc     = 3'd2;
  localparam logic [2:0] StScrlInit = 3'd3;
  localparam logic [2:0] StScroll   = 3'd4;
  localparam logic [2:0] StDone     = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [ColW-1:0]  cols_q, rows_cfg_unused;
  logic [RowW-1:0]  rows_q;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RowW-1:0]  cur_row_q, cur_row_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [AddrW-1:0] wk_q, wk_d;
  logic             wpend_q, wpend_d;
  logic             zero_q, zero_d;
  logic             out_valid_q, out_valid_d;

  logic [ReqW-1:0]  req_q;
  logic [CharW-1:0] ch_q;
  logic [AttrW-1:0] attr_q;
  logic [ColW-1:0]  tcol_q;
  logic [RowW-1:0]  trow_q;

  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic [AttrW-1:0] out_attr_q, out_attr_d;

  logic [ColW-1:0]  cols_c, cols_m1, col_clamp, tcol_clamp;
  logic [RowW-1:0]  rows_c, rows_m1, row_clamp, trow_clamp;
  logic [ColW:0]    col_inc;
  logic [RowW:0]    row_inc;
  logic             accept, out_free, out_load, newline;

  logic [RowW-1:0]  mul_a;
  logic [CntW-1:0]  mul_c;
  logic [SumW-1:0]  mul_res;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  assign rows_cfg_unused = '0;

  // active size
  always_comb begin
    if (cols_q == '0) begin
      cols_c = ColW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_c = ColW'(MAX_COLS);
    end else begin
      cols_c = cols_q;
    end
    if (rows_q == '0) begin
      rows_c = RowW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_c = RowW'(MAX_ROWS);
    end else begin
      rows_c = rows_q;
    end
  end

  assign cols_m1    = cols_c - ColW'(1);
  assign rows_m1    = rows_c - RowW'(1);
  assign col_clamp  = (cur_col_q > cols_m1) ? cols_m1 : cur_col_q;
  assign row_clamp  = (cur_row_q > rows_m1) ? rows_m1 : cur_row_q;
  assign tcol_clamp = (req_if.target_col > cols_m1) ? cols_m1 : req_if.target_col;
  assign trow_clamp = (req_if.target_row > rows_m1) ? rows_m1 : req_if.target_row;
  assign col_inc    = {1'b0, cur_col_q} + (ColW + 1)'(1);
  assign row_inc    = {1'b0, cur_row_q} + (RowW + 1)'(1);

  assign req_if.ready = (state_q == StIdle);
  assign accept       = req_if.valid && req_if.ready;
  assign out_free     = !out_valid_q || rsp_if.ready;

  // shared multiply-add: row * cols + col (col - 1 on backspace), rows * cols, k + cols
  always_comb begin
    mul_a = '0;
    mul_c = '0;
    unique case (state_q)
      StCalc: begin
        if (req_q == ReqRead) begin
          mul_a = trow_q;
          mul_c = CntW'(tcol_q);
        end else if (ch_q == CharBackspace) begin
          mul_a = cur_row_q;
          mul_c = CntW'(cur_col_q - ColW'(1));
        end else begin
          mul_a = cur_row_q;
          mul_c = CntW'(cur_col_q);
        end
      end
      StScrlInit: begin
        mul_a = rows_c;
      end
      StScroll: begin
        mul_a = RowW'(1);
        mul_c = k_q;
      end
      default: begin
      end
    endcase
  end

  tcw_addr_unit #(
    .CntW(CntW)
  ) u_addr (
    .a_i  (mul_a),
    .b_i  (cols_c),
    .c_i  (mul_c),
    .sum_o(mul_res)
  );

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    clr_d       = clr_q;
    total_d     = total_q;
    k_d         = k_q;
    wk_d        = wk_q;
    wpend_d     = wpend_q;
    zero_d      = zero_q;
    out_load    = 1'b0;
    newline     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = mul_res[AddrW-1:0];
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = mul_res[AddrW-1:0];

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          cur_col_d = col_clamp;
          cur_row_d = row_clamp;
          state_d   = StCalc;
        end
      end
      StCalc: begin
        unique case (req_q)
          ReqWrite: begin
            if (ch_q == CharNewline) begin
              newline = 1'b1;
            end else if (ch_q == CharBackspace) begin
              if (cur_col_q != '0) begin
                ram_we    = 1'b1;
                ram_wdata = {attr_q, CharSpace};
                cur_col_d = cur_col_q - ColW'(1);
              end
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {attr_q, ch_q};
              if (col_inc >= {1'b0, cols_c}) begin
                newline = 1'b1;
              end else begin
                cur_col_d = col_inc[ColW-1:0];
              end
            end
          end
          ReqSetCursor: begin
            cur_col_d = tcol_q;
            cur_row_d = trow_q;
          end
          ReqRead: begin
            ram_re = 1'b1;
          end
          default: begin
          end
        endcase
        if (newline) begin
          cur_col_d = '0;
          if (row_inc >= {1'b0, rows_c}) begin
            cur_row_d = rows_m1;
          end else begin
            cur_row_d = row_inc[RowW-1:0];
          end
        end
        if (newline && (row_inc >= {1'b0, rows_c})) begin
          state_d = StScrlInit;
        end else if ((req_q != ReqRead) && out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end else begin
          state_d = StDone;
        end
      end
      StScrlInit: begin
        total_d = mul_res[CntW-1:0];
        k_d     = '0;
        wpend_d = 1'b0;
        state_d = StScroll;
      end
      StScroll: begin
        // read cell k + cols, write it (zero past the end) to cell k in the next cycle
        ram_we    = wpend_q;
        ram_waddr = wk_q;
        ram_wdata = zero_q ? '0 : ram_rdata;
        if (k_q != total_q) begin
          ram_re  = (mul_res < {1'b0, total_q});
          zero_d  = (mul_res >= {1'b0, total_q});
          wk_d    = k_q[AddrW-1:0];
          wpend_d = 1'b1;
          k_d     = k_q + CntW'(1);
        end else begin
          wpend_d = 1'b0;
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_char_d = '0;
    out_attr_d = '0;
    if ((state_q == StDone) && (req_q == ReqRead)) begin
      out_char_d = ram_rdata[CharW-1:0];
      out_attr_d = ram_rdata[CellW-1:CharW];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  tcw_ram #(
    .Width(CellW),
    .Depth(Depth)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cols_q      <= ColsReset;
      rows_q      <= RowsReset;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      clr_q       <= '0;
      total_q     <= '0;
      k_q         <= '0;
      wk_q        <= '0;
      wpend_q     <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      k_q         <= k_d;
      wk_q        <= wk_d;
      wpend_q     <= wpend_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgColumns: cols_q <= cfg_data_i[ColW-1:0] | rows_cfg_unused;
          CfgRows:    rows_q <= cfg_data_i[RowW-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_if.req_type;
      ch_q   <= req_if.char_code;
      attr_q <= {ansi_to_vga(req_if.bg_color), ansi_to_vga(req_if.fg_color)};
      tcol_q <= tcol_clamp;
      trow_q <= trow_clamp;
    end
    if (out_load) begin
      out_col_q  <= cur_col_d;
      out_row_q  <= cur_row_d;
      out_char_q <= out_char_d;
      out_attr_q <= out_attr_d;
    end
  end

  assign rsp_if.valid      = out_valid_q;
  assign rsp_if.cursor_col = out_col_q;
  assign rsp_if.cursor_row = out_row_q;
  assign rsp_if.cell_char  = out_char_q;
  assign rsp_if.cell_attr  = out_attr_q;

endmodule

/* rtl/core/tcw_checker.sv */
module tcw_checker import tcw_pkg::*; #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 25
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ColW-1:0]  cursor_col_i,
  input logic [RowW-1:0]  cursor_row_i,
  input logic [CharW-1:0] cell_char_i,
  input logic [AttrW-1:0] cell_attr_i
);

  // result held while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(cursor_col_i) && $stable(cursor_row_i) &&
      $stable(cell_char_i) && $stable(cell_attr_i))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // reported cursor stays on the largest screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(cursor_col_i) < MAX_COLS) && (int'(cursor_row_i) < MAX_ROWS))
    else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
  .MAX_COLS(MAX_COLS),
  .MAX_ROWS(MAX_ROWS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_if.valid),
  .in_ready_i  (req_if.ready),
  .out_valid_i (rsp_if.valid),
  .out_ready_i (rsp_if.ready),
  .cursor_col_i(rsp_if.cursor_col),
  .cursor_row_i(rsp_if.cursor_row),
  .cell_char_i (rsp_if.cell_char),
  .cell_attr_i (rsp_if.cell_attr)
);
